>>> rtl/core/dwmq_pkg.sv
// Shared constants, types and helpers for the distance weighted min query block.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package dwmq_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int PRICE_BITS  = 30;

    localparam int IDX_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int NODE_AW    = IDX_W + 1;
    localparam int NODES      = 2 * MAX_ENTRIES;
    localparam int VAL_W      = PRICE_BITS + 2;
    localparam int COST_W     = PRICE_BITS + 1;
    localparam int UPD_LEVELS = IDX_W;
    localparam int QRY_ITERS  = IDX_W + 1;

    // Empty node: largest positive node value, above any price plus position.
    localparam logic signed [VAL_W-1:0] EMPTY_VAL = {1'b0, {(VAL_W-1){1'b1}}};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_UPD_LEAF,
        ST_UPD_LVL,
        ST_QRY_RUN,
        ST_QRY_DRAIN,
        ST_QRY_FIN
    } t_state;

    typedef struct packed {
        logic               clr;
        logic [NODE_AW-1:0] clr_addr;
        logic               load;
        logic               init_upd;
        logic               init_qry;
        logic               upd_leaf;
        logic               upd_lvl;
        logic               qry_step;
        logic               finish;
    } t_dp_cmd;

    typedef struct packed {
        logic is_query;
        logic bad;
    } t_dp_sts;

    function automatic logic signed [VAL_W-1:0] vmin(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/distance_weighted_min_query.sv
// After reset the block sweeps both 2048-node tree memories to the empty value, one node
// per cycle, and busy stays high throughout; writes to the entry-count register are
// taken during that sweep. A request is taken when start is high and busy is low. An
// update keeps busy high through decode, the leaf write and then one tree level per cycle
// for 10 levels, and returns nothing. A query keeps busy high through decode, 11 walk
// steps with two registered reads per tree per step, a drain state and a result state;
// o_done pulses for one cycle at the first idle cycle, carrying o_best_cost and
// o_bad_index. A query outside the entries in use goes from decode to the result state
// with o_bad_index set and a zero cost. The rate is set by the registered read ports of
// the node memories, one tree level per cycle. o_done lasts one cycle and cannot stall.
// Depends on dwmq_pkg, dwmq_ctrl and dwmq_dp.
`default_nettype none

module distance_weighted_min_query (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                i_cfg_we,
    input  wire logic [dwmq_pkg::CNT_W-1:0]          i_cfg_wdata,
    input  wire logic                                i_req_type,
    input  wire logic [dwmq_pkg::IDX_W-1:0]          i_position,
    input  wire logic [dwmq_pkg::PRICE_BITS-1:0]     i_new_price,
    output logic                                     o_done,
    output logic      [dwmq_pkg::COST_W-1:0]         o_best_cost,
    output logic                                     o_bad_index
);
    import dwmq_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    dwmq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    dwmq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_type  (i_req_type),
        .i_position  (i_position),
        .i_new_price (i_new_price),
        .o_done      (o_done),
        .o_best_cost (o_best_cost),
        .o_bad_index (o_bad_index)
    );

    // A transfer in always leaves the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // A result only follows the finish command.
    a_done_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_cmd.finish))
        else $error("result strobe without finish command");

    // The controller never issues two datapath operations at once.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.clr, w_cmd.load, w_cmd.init_upd, w_cmd.init_qry,
                  w_cmd.upd_leaf, w_cmd.upd_lvl, w_cmd.qry_step, w_cmd.finish}))
        else $error("overlapping datapath commands");

endmodule

`default_nettype wire

>>> rtl/core/dwmq_tree.sv
// One min segment tree: node memory, leaf-to-root refresh path and range-min walk.
// Depends on dwmq_pkg; instantiated twice by dwmq_dp.
`default_nettype none

module dwmq_tree (
    input  wire logic                                    i_clk,
    input  wire dwmq_pkg::t_dp_cmd                       i_cmd,
    input  wire logic        [dwmq_pkg::IDX_W-1:0]       i_leaf_pos,
    input  wire logic signed [dwmq_pkg::VAL_W-1:0]       i_leaf_val,
    input  wire logic        [dwmq_pkg::IDX_W-1:0]       i_lo,
    input  wire logic        [dwmq_pkg::IDX_W-1:0]       i_hi,
    output logic signed      [dwmq_pkg::VAL_W-1:0]       o_min
);
    import dwmq_pkg::*;

    logic signed [VAL_W-1:0]   r_mem [NODES];
    logic signed [VAL_W-1:0]   r_rd0;
    logic signed [VAL_W-1:0]   r_rd1;
    logic        [NODE_AW-1:0] r_node;
    logic signed [VAL_W-1:0]   r_val;
    logic        [NODE_AW:0]   r_l;
    logic        [NODE_AW:0]   r_r;
    logic                      r_take_l;
    logic                      r_take_r;
    logic signed [VAL_W-1:0]   r_acc;

    logic                      w_we;
    logic        [NODE_AW-1:0] w_waddr;
    logic signed [VAL_W-1:0]   w_wdata;
    logic        [NODE_AW-1:0] w_raddr0;
    logic        [NODE_AW-1:0] w_raddr1;
    logic        [NODE_AW-1:0] w_parent;
    logic signed [VAL_W-1:0]   w_merged;
    logic        [NODE_AW:0]   w_r_m1;
    logic        [NODE_AW:0]   w_l_next;
    logic                      w_live;
    logic signed [VAL_W-1:0]   w_pick_l;
    logic signed [VAL_W-1:0]   w_pick_r;

    assign w_parent = r_node >> 1;
    assign w_merged = vmin(r_val, r_rd0);
    assign w_r_m1   = r_r - (NODE_AW+1)'(1);
    assign w_l_next = (r_l + (NODE_AW+1)'(r_l[0])) >> 1;
    assign w_live   = r_l < r_r;
    assign w_pick_l = r_take_l ? r_rd0 : EMPTY_VAL;
    assign w_pick_r = r_take_r ? r_rd1 : EMPTY_VAL;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = i_cmd.clr_addr;
        w_wdata = EMPTY_VAL;
        if (i_cmd.clr) begin
            w_we = 1'b1;
        end else if (i_cmd.upd_leaf) begin
            w_we    = 1'b1;
            w_waddr = r_node;
            w_wdata = r_val;
        end else if (i_cmd.upd_lvl) begin
            w_we    = 1'b1;
            w_waddr = w_parent;
            w_wdata = w_merged;
        end
    end

    // Port 0 fetches the sibling on the refresh path, else the left walk node.
    always_comb begin
        if (i_cmd.upd_leaf) begin
            w_raddr0 = r_node ^ NODE_AW'(1);
        end else if (i_cmd.upd_lvl) begin
            w_raddr0 = w_parent ^ NODE_AW'(1);
        end else begin
            w_raddr0 = r_l[NODE_AW-1:0];
        end
    end

    assign w_raddr1 = w_r_m1[NODE_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd0 <= r_mem[w_raddr0];
        r_rd1 <= r_mem[w_raddr1];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_upd) begin
            r_node <= {1'b1, i_leaf_pos};
            r_val  <= i_leaf_val;
        end else if (i_cmd.upd_lvl) begin
            r_node <= w_parent;
            r_val  <= w_merged;
        end

        if (i_cmd.init_qry) begin
            r_l <= {2'b01, i_lo};
            r_r <= {2'b01, i_hi} + (NODE_AW+1)'(1);
        end else if (i_cmd.qry_step) begin
            r_l <= w_l_next;
            r_r <= r_r >> 1;
        end

        // Read data is registered and lands in the cycle after the step; the flags travel with it.
        r_take_l <= i_cmd.qry_step & w_live & r_l[0];
        r_take_r <= i_cmd.qry_step & w_live & r_r[0];

        if (i_cmd.init_qry) begin
            r_acc <= EMPTY_VAL;
        end else begin
            r_acc <= vmin(r_acc, vmin(w_pick_l, w_pick_r));
        end
    end

    assign o_min = r_acc;

endmodule

`default_nettype wire

>>> rtl/core/dwmq_dp.sv
// Datapath: request and configuration registers, the two trees and the result register.
// Depends on dwmq_pkg and dwmq_tree; driven by dwmq_ctrl through a command struct.
`default_nettype none

module dwmq_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire dwmq_pkg::t_dp_cmd                   i_cmd,
    output dwmq_pkg::t_dp_sts                        o_sts,
    input  wire logic                                i_cfg_we,
    input  wire logic [dwmq_pkg::CNT_W-1:0]          i_cfg_wdata,
    input  wire logic                                i_req_type,
    input  wire logic [dwmq_pkg::IDX_W-1:0]          i_position,
    input  wire logic [dwmq_pkg::PRICE_BITS-1:0]     i_new_price,
    output logic                                     o_done,
    output logic      [dwmq_pkg::COST_W-1:0]         o_best_cost,
    output logic                                     o_bad_index
);
    import dwmq_pkg::*;

    logic [CNT_W-1:0]        r_entries;
    logic                    r_type;
    logic [IDX_W-1:0]        r_pos;
    logic [PRICE_BITS-1:0]   r_price;
    logic                    r_bad;
    logic [IDX_W-1:0]        r_last;
    logic                    r_done;
    logic [COST_W-1:0]       r_cost;
    logic                    r_bad_out;

    logic [CNT_W-1:0]        w_n;
    logic [CNT_W-1:0]        w_n_m1;
    logic signed [VAL_W-1:0] w_pos_s;
    logic signed [VAL_W-1:0] w_price_s;
    logic signed [VAL_W-1:0] w_minus_leaf;
    logic signed [VAL_W-1:0] w_plus_leaf;
    logic signed [VAL_W-1:0] w_minus_min;
    logic signed [VAL_W-1:0] w_plus_min;
    logic signed [VAL_W-1:0] w_cand_up;
    logic signed [VAL_W-1:0] w_cand_dn;
    logic signed [VAL_W-1:0] w_best;
    logic                    w_up_ok;
    logic                    w_dn_ok;
    logic [COST_W-1:0]       w_cost;

    assign w_n    = (r_entries > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : r_entries;
    assign w_n_m1 = w_n - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= CNT_W'(MAX_ENTRIES);
        end else if (i_cfg_we) begin
            r_entries <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type  <= i_req_type;
            r_pos   <= i_position;
            r_price <= i_new_price;
            r_bad   <= {1'b0, i_position} >= w_n;
            r_last  <= w_n_m1[IDX_W-1:0];
        end
    end

    assign o_sts.is_query = r_type;
    assign o_sts.bad      = r_bad;

    assign w_pos_s      = $signed({{(VAL_W-IDX_W){1'b0}}, r_pos});
    assign w_price_s    = $signed({2'b00, r_price});
    assign w_minus_leaf = w_price_s - w_pos_s;
    assign w_plus_leaf  = w_price_s + w_pos_s;

    // Minus tree covers [0, k], plus tree covers [k, n-1].
    dwmq_tree u_minus_tree (
        .i_clk      (i_clk),
        .i_cmd      (i_cmd),
        .i_leaf_pos (r_pos),
        .i_leaf_val (w_minus_leaf),
        .i_lo       ('0),
        .i_hi       (r_pos),
        .o_min      (w_minus_min)
    );

    dwmq_tree u_plus_tree (
        .i_clk      (i_clk),
        .i_cmd      (i_cmd),
        .i_leaf_pos (r_pos),
        .i_leaf_val (w_plus_leaf),
        .i_lo       (r_pos),
        .i_hi       (r_last),
        .o_min      (w_plus_min)
    );

    assign w_up_ok   = w_plus_min != EMPTY_VAL;
    assign w_dn_ok   = w_minus_min != EMPTY_VAL;
    assign w_cand_up = w_plus_min - w_pos_s;
    assign w_cand_dn = w_minus_min + w_pos_s;

    always_comb begin
        if (w_up_ok && w_dn_ok) begin
            w_best = vmin(w_cand_up, w_cand_dn);
        end else if (w_up_ok) begin
            w_best = w_cand_up;
        end else begin
            w_best = w_cand_dn;
        end
    end

    // No written entry in range, or a negative sum: saturate to all ones.
    assign w_cost = ((!w_up_ok && !w_dn_ok) || w_best[VAL_W-1]) ? '1 : w_best[COST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_cost    <= r_bad ? '0 : w_cost;
            r_bad_out <= r_bad;
        end
    end

    assign o_done      = r_done;
    assign o_best_cost = r_cost;
    assign o_bad_index = r_bad_out;

endmodule

`default_nettype wire

>>> rtl/core/dwmq_ctrl.sv
// Controller: state machine and step counter that sequence clear, update and query work.
// Depends on dwmq_pkg; issues t_dp_cmd to dwmq_dp and reads back t_dp_sts.
`default_nettype none

module dwmq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire dwmq_pkg::t_dp_sts i_sts,
    output logic                   o_busy,
    output dwmq_pkg::t_dp_cmd      o_cmd
);
    import dwmq_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [NODE_AW-1:0] r_cnt;
    logic [NODE_AW-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_cnt == NODE_AW'(NODES - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (!i_sts.is_query) begin
                    n_state = ST_UPD_LEAF;
                end else if (i_sts.bad) begin
                    n_state = ST_QRY_FIN;
                end else begin
                    n_state = ST_QRY_RUN;
                end
            end
            ST_UPD_LEAF: n_state = ST_UPD_LVL;
            ST_UPD_LVL: begin
                if (r_cnt == NODE_AW'(UPD_LEVELS - 1)) n_state = ST_IDLE;
            end
            ST_QRY_RUN: begin
                if (r_cnt == NODE_AW'(QRY_ITERS - 1)) n_state = ST_QRY_DRAIN;
            end
            ST_QRY_DRAIN: n_state = ST_QRY_FIN;
            ST_QRY_FIN:   n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Count while staying in a looping state; restart from zero on any move.
    always_comb begin
        n_cnt = '0;
        if ((r_state inside {ST_CLEAR, ST_UPD_LVL, ST_QRY_RUN}) && (n_state == r_state)) begin
            n_cnt = r_cnt + NODE_AW'(1);
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.clr_addr = r_cnt;
        o_busy         = 1'b1;
        case (r_state)
            ST_CLEAR:    o_cmd.clr = 1'b1;
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_DECODE: begin
                o_cmd.init_upd = !i_sts.is_query;
                o_cmd.init_qry = i_sts.is_query;
            end
            ST_UPD_LEAF:  o_cmd.upd_leaf = 1'b1;
            ST_UPD_LVL:   o_cmd.upd_lvl  = 1'b1;
            ST_QRY_RUN:   o_cmd.qry_step = 1'b1;
            ST_QRY_DRAIN: o_cmd.qry_step = 1'b0;
            ST_QRY_FIN:   o_cmd.finish   = 1'b1;
            default:      o_busy         = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

>>> sim/distance_weighted_min_query_test.sv
// Self-checking bench for distance_weighted_min_query: price updates and weighted-cost queries
// against a price-table predictor, across several entry-count settings.
// Depends on dwmq_pkg and the distance_weighted_min_query RTL.
module distance_weighted_min_query_test;
    import dwmq_pkg::MAX_ENTRIES;
    import dwmq_pkg::IDX_W;
    import dwmq_pkg::CNT_W;
    import dwmq_pkg::PRICE_BITS;
    import dwmq_pkg::COST_W;

    localparam int          HALF_PERIOD  = 6;
    localparam int          RESET_CYCLES = 6;
    localparam int          SETTLE       = 20;
    localparam int          TAIL         = 32;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          PHASE_ITEMS  = 85;
    localparam int          PHASES       = 8;
    localparam logic [COST_W-1:0]     COST_ALL_ONES = '1;
    localparam logic [PRICE_BITS-1:0] PRICE_MAX     = '1;

    typedef enum logic {REQ_SET_PRICE = 1'b0, REQ_QUERY = 1'b1} t_req;
    typedef enum logic [1:0] {JOB_REQUEST, JOB_SET_SIZE, JOB_DRAIN} t_job_kind;

    typedef struct {
        t_job_kind              kind;
        t_req                   req;
        logic [IDX_W-1:0]       pos;
        logic [PRICE_BITS-1:0]  price;
        logic [CNT_W-1:0]       size;
        int unsigned            gap;
    } t_job;

    typedef struct {
        logic [COST_W-1:0] cost;
        logic              bad;
    } t_cost_result;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   start       = 1'b0;
    logic                   busy;
    logic                   i_cfg_we    = 1'b0;
    logic [CNT_W-1:0]       i_cfg_wdata = '0;
    logic                   i_req_type  = 1'b0;
    logic [IDX_W-1:0]       i_position  = '0;
    logic [PRICE_BITS-1:0]  i_new_price = '0;
    logic                   o_done;
    logic [COST_W-1:0]      o_best_cost;
    logic                   o_bad_index;

    distance_weighted_min_query u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_type  (i_req_type),
        .i_position  (i_position),
        .i_new_price (i_new_price),
        .o_done      (o_done),
        .o_best_cost (o_best_cost),
        .o_bad_index (o_bad_index)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Predictor state: one price per slot, plus whether it was ever written.
    logic [PRICE_BITS-1:0]  price_tab [MAX_ENTRIES];
    bit                     price_valid [MAX_ENTRIES];
    logic [CNT_W-1:0]       entries_cfg = CNT_W'(MAX_ENTRIES);

    t_job                   jobs [$];
    t_cost_result           pending_costs [$];

    int unsigned queries_issued = 0;
    int unsigned costs_seen     = 0;
    int unsigned updates_issued = 0;
    int unsigned bad_expected   = 0;
    int unsigned size_writes    = 0;
    int unsigned drains         = 0;
    int unsigned mismatches     = 0;
    int unsigned quiet_cnt      = 0;
    int unsigned hold_cnt       = 0;
    int unsigned cur_gap        = 0;
    int unsigned cycle_cnt      = 0;
    bit          burst_mode     = 1'b0;

    function automatic t_cost_result cheapest_cost(input logic [IDX_W-1:0] at);
        t_cost_result      res;
        int unsigned       span;
        longint unsigned   best;
        longint unsigned   cand;
        int                hop_len;
        bit                found;
        span     = (entries_cfg > MAX_ENTRIES) ? MAX_ENTRIES : entries_cfg;
        res.cost = '0;
        res.bad  = 1'b0;
        found    = 1'b0;
        best     = 0;
        if (at >= span) begin
            res.bad = 1'b1;
        end else begin
            for (int j = 0; j < span; j++) begin
                if (price_valid[j]) begin
                    hop_len = int'(at) - j;
                    if (hop_len < 0) hop_len = -hop_len;
                    cand = longint'(price_tab[j]) + longint'(hop_len);
                    if (!found || cand < best) begin
                        best  = cand;
                        found = 1'b1;
                    end
                end
            end
            res.cost = (!found || best > COST_ALL_ONES) ? COST_ALL_ONES : best[COST_W-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic add_req(input t_req req, input int unsigned pos, input logic [PRICE_BITS-1:0] price);
        t_job j;
        j.kind  = JOB_REQUEST;
        j.req   = req;
        j.pos   = IDX_W'(pos);
        j.price = price;
        j.size  = '0;
        j.gap   = burst_mode ? 0 : $urandom_range(0, 8);
        jobs.push_back(j);
    endtask

    task automatic add_size(input int unsigned size);
        t_job j;
        j.kind  = JOB_SET_SIZE;
        j.req   = REQ_SET_PRICE;
        j.pos   = '0;
        j.price = '0;
        j.size  = CNT_W'(size);
        j.gap   = 0;
        jobs.push_back(j);
    endtask

    task automatic add_drain();
        t_job j;
        j.kind  = JOB_DRAIN;
        j.req   = REQ_SET_PRICE;
        j.pos   = '0;
        j.price = '0;
        j.size  = '0;
        j.gap   = 0;
        jobs.push_back(j);
    endtask

    // Driver: hold each request until the transfer, then wait out its gap before the next.
    always @(posedge i_clk) begin : drive_proc
        logic         nxt_start;
        logic         nxt_we;
        t_job         job;
        t_cost_result res;
        nxt_start = start;
        nxt_we    = 1'b0;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else begin
            if (start && !busy) begin
                if (t_req'(i_req_type) == REQ_SET_PRICE) begin
                    price_tab[i_position]   = i_new_price;
                    price_valid[i_position] = 1'b1;
                    updates_issued++;
                end else begin
                    res = cheapest_cost(i_position);
                    pending_costs.push_back(res);
                    queries_issued++;
                    if (res.bad) bad_expected++;
                end
                nxt_start = 1'b0;
                hold_cnt  = cur_gap;
            end
            if (start || busy || queries_issued != costs_seen) quiet_cnt = 0;
            else quiet_cnt++;
            if (!nxt_start) begin
                if (hold_cnt != 0) begin
                    hold_cnt--;
                end else if (jobs.size() != 0) begin
                    job = jobs[0];
                    case (job.kind)
                        JOB_REQUEST: begin
                            void'(jobs.pop_front());
                            i_req_type  <= job.req;
                            i_position  <= job.pos;
                            i_new_price <= job.price;
                            cur_gap     = job.gap;
                            nxt_start   = 1'b1;
                        end
                        JOB_SET_SIZE: begin
                            // Only write the count once the block has been idle a while.
                            if (quiet_cnt >= SETTLE) begin
                                void'(jobs.pop_front());
                                i_cfg_wdata <= job.size;
                                nxt_we      = 1'b1;
                                entries_cfg = job.size;
                                size_writes++;
                                quiet_cnt   = 0;
                            end
                        end
                        default: begin
                            if (queries_issued == costs_seen) begin
                                void'(jobs.pop_front());
                                drains++;
                            end
                        end
                    endcase
                end
            end
        end
        start    <= nxt_start;
        i_cfg_we <= nxt_we;
    end

    // Monitor: every strobe is a transfer, match it against the oldest expectation.
    always @(posedge i_clk) begin : watch_proc
        t_cost_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_costs.size() == 0) begin
                report_mismatch("result with no query outstanding", o_best_cost, 0);
            end else begin
                want = pending_costs.pop_front();
                if (o_bad_index !== want.bad)
                    report_mismatch("bad_index", o_bad_index, want.bad);
                if (o_best_cost !== want.cost)
                    report_mismatch("best_cost", o_best_cost, want.cost);
            end
            costs_seen <= costs_seen + 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("distance_weighted_min_query verification failed");
            $finish;
        end
    end

    initial begin : stim_proc
        int unsigned sz;
        int unsigned span;
        int unsigned pos;
        int unsigned r;
        int unsigned drain_at;
        logic [PRICE_BITS-1:0] price;
        t_req req;

        // Directed: empty table, extremes of position and price, count corner values.
        add_size(MAX_ENTRIES);
        add_req(REQ_QUERY, 0, '0);
        add_req(REQ_QUERY, MAX_ENTRIES - 1, '0);
        add_req(REQ_SET_PRICE, 0, '0);
        add_req(REQ_SET_PRICE, MAX_ENTRIES - 1, PRICE_MAX);
        add_req(REQ_SET_PRICE, 512, 5);
        add_req(REQ_QUERY, 0, '0);
        add_req(REQ_QUERY, MAX_ENTRIES - 1, PRICE_MAX);
        add_req(REQ_QUERY, 700, '0);
        add_req(REQ_SET_PRICE, MAX_ENTRIES - 1, '0);
        add_req(REQ_QUERY, MAX_ENTRIES - 1, '0);
        add_size(1);
        add_req(REQ_QUERY, 0, '0);
        add_req(REQ_QUERY, 1, '0);
        add_req(REQ_QUERY, MAX_ENTRIES - 1, '0);
        add_req(REQ_SET_PRICE, 5, 3);      // beyond entries in use, visible later
        add_size(2047);
        add_req(REQ_QUERY, 5, '0);
        add_size(0);
        add_req(REQ_QUERY, 0, '0);
        add_size(MAX_ENTRIES);
        add_req(REQ_SET_PRICE, 0, PRICE_MAX);
        add_req(REQ_SET_PRICE, 512, PRICE_MAX);
        add_req(REQ_SET_PRICE, 5, PRICE_MAX);
        add_req(REQ_SET_PRICE, MAX_ENTRIES - 1, PRICE_MAX);
        add_req(REQ_QUERY, 300, '0);
        add_req(REQ_QUERY, MAX_ENTRIES - 1, '0);

        // Random phases, each under its own entry count.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       sz = MAX_ENTRIES;
                1:       sz = 16;
                2:       sz = 1;
                3:       sz = 2047;
                4:       sz = 0;
                5:       sz = $urandom_range(2, 64);
                6:       sz = $urandom_range(1, MAX_ENTRIES);
                default: sz = MAX_ENTRIES;
            endcase
            burst_mode = (p % 3 == 1);
            add_size(sz);
            span = (sz == 0 || sz > MAX_ENTRIES) ? MAX_ENTRIES : sz;
            drain_at = (p == 2 || $urandom_range(0, 1) == 1) ? $urandom_range(10, 75) : PHASE_ITEMS;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == drain_at) add_drain();
                r = $urandom_range(0, 99);
                if (r < 75) pos = $urandom_range(0, span - 1);
                else if (r < 80) pos = 0;
                else if (r < 85) pos = (span < MAX_ENTRIES) ? span : span - 1;
                else if (r < 88) pos = span - 1;
                else pos = $urandom_range(0, MAX_ENTRIES - 1);
                r = $urandom_range(0, 99);
                if (r < 40) price = $urandom_range(0, 2000);
                else if (r < 45) price = '0;
                else if (r < 50) price = PRICE_MAX;
                else price = PRICE_BITS'($urandom());
                req = ($urandom_range(0, 99) < 45) ? REQ_SET_PRICE : REQ_QUERY;
                add_req(req, pos, price);
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (jobs.size() != 0 || start || queries_issued != costs_seen);
        repeat (TAIL) @(negedge i_clk);
        if (pending_costs.size() != 0)
            report_mismatch("queries left without a result", pending_costs.size(), 0);

        $display("covered %0d price updates and %0d queries (%0d out of range)",
                 updates_issued, queries_issued, bad_expected);
        $display("under %0d entry-count writes with %0d full drains; %0d mismatches",
                 size_writes, drains, mismatches);
        if (mismatches == 0) begin
            $display("distance_weighted_min_query verification clean");
        end else begin
            $display("distance_weighted_min_query verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/dwmq_pkg.sv
rtl/core/dwmq_tree.sv
rtl/core/dwmq_dp.sv
rtl/core/dwmq_ctrl.sv
rtl/core/distance_weighted_min_query.sv
sim/distance_weighted_min_query_test.sv
